// File: rtl/kmer_histogram_counter_top_assert.svh
// Assertion macros shared by the counter RTL.
`ifndef KMER_HISTOGRAM_COUNTER_TOP_ASSERT_SVH
`define KMER_HISTOGRAM_COUNTER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define KHC_ASSERT_IMP(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define KHC_ASSERT_NXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/kmerhc_pkg.sv
package kmerhc_pkg;

	localparam int unsigned CNT_W      = 8;
	localparam int unsigned ADDR_MAX_W = 16;

	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// Write request into the counter table.
	typedef struct packed {
		logic                  en;
		logic [ADDR_MAX_W-1:0] addr;
		count_t                data;
	} tbl_wr_t;

endpackage

// File: rtl/kmerhc_table.sv
`include "kmer_histogram_counter_top_assert.svh"

module kmerhc_table #(
	parameter int unsigned ADDR_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output kmerhc_pkg::count_t   rd_data,
	input  kmerhc_pkg::tbl_wr_t  wr,
	output logic                 busy
);
	import kmerhc_pkg::*;

	localparam int unsigned DEPTH = 2 ** ADDR_W;

	count_t              mem [DEPTH];
	count_t              rd_data_q;
	logic [ADDR_W:0]     clr_addr_q;

	// The top bit of the sweep counter marks the end of the clearing pass.
	assign busy    = !clr_addr_q[ADDR_W];
	assign rd_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (busy) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_addr_q[ADDR_W-1:0]] <= '0;
		end else if (wr.en) begin
			mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	`KHC_ASSERT_NXT(a_clear_once, clk, arst_n, !busy, !busy)
	`KHC_ASSERT_IMP(a_no_rd_in_clear, clk, arst_n, busy, !rd_en)

endmodule

// File: rtl/kmer_histogram_counter_top.sv
// Channel   Handshake             Payload                                  Direction
// req       req_valid/req_stall   operation, symbol, first_symbol,         into block
//                                 read_index
// rsp       rsp_valid/rsp_stall   count                                    out of block
//
// The block takes one request beat per cycle while req_stall is low; a push and a read may
// follow each other freely. A read's count passes through stage one and the response
// register; a push returns nothing. After reset a clearing pass zeroes all
// 2**min(16, WINDOW_LENGTH*LETTER_BITS) entries of the counter table (65536 at the defaults),
// one entry per cycle; req_stall is high meanwhile. The single write port of the table memory
// sets the rate: one read-modify-write per cycle while req_stall is low. While a read result
// waits on a stalled response register, pushes keep flowing; the next read is accepted, holds
// in stage one and stalls the whole request channel until it drains.

`include "kmer_histogram_counter_top_assert.svh"

module kmer_histogram_counter_top #(
	parameter int unsigned WINDOW_LENGTH = 8,
	parameter int unsigned LETTER_BITS   = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               operation,
	input  logic [1:0]         symbol,
	input  logic               first_symbol,
	input  logic [15:0]        read_index,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output kmerhc_pkg::count_t count
);
	import kmerhc_pkg::*;

	// The window code keeps at most sixteen bits; the table holds one counter per code.
	localparam int unsigned CODE_BITS = WINDOW_LENGTH * LETTER_BITS;
	localparam int unsigned IDX_W     = (CODE_BITS >= ADDR_MAX_W) ? ADDR_MAX_W : CODE_BITS;
	localparam int unsigned FILL_W    = $clog2(WINDOW_LENGTH + 1);

	// Window state, updated as soon as a push beat is accepted.
	logic [IDX_W-1:0]             window_q;
	logic [FILL_W-1:0]            fill_q;
	logic [IDX_W-1:0]             base_window;
	logic [IDX_W+LETTER_BITS-1:0] shifted;
	logic [IDX_W-1:0]             next_window;
	logic [FILL_W-1:0]            base_fill;
	logic [FILL_W-1:0]            next_fill;
	logic                         push_inc;

	// Stage one: the table read is in flight and its data arrives here.
	logic                         valid_s1;
	logic                         read_s1;
	logic                         inc_s1;
	logic                         oob_s1;
	logic                         hit_s1;
	count_t                       fwd_s1;
	logic [IDX_W-1:0]             addr_s1;

	logic                         accept;
	logic                         is_read;
	logic                         oob;
	logic                         s1_adv;
	logic [IDX_W-1:0]             rd_addr;
	count_t                       tbl_rd_data;
	count_t                       cur_s1;
	tbl_wr_t                      wr;
	logic                         tbl_busy;

	logic                         rsp_valid_q;
	count_t                       count_q;

	assign accept  = req_valid && !req_stall;
	assign is_read = (op_t'(operation) == OP_READ);

	// A start flag clears the window before the new letter is shifted in.
	always_comb begin
		base_window = first_symbol ? '0 : window_q;
		base_fill   = first_symbol ? '0 : fill_q;
		shifted     = {base_window, symbol[LETTER_BITS-1:0]};
		next_window = shifted[IDX_W-1:0];
		if (base_fill < FILL_W'(WINDOW_LENGTH)) begin
			next_fill = base_fill + 1'b1;
		end else begin
			next_fill = base_fill;
		end
		push_inc = (next_fill == FILL_W'(WINDOW_LENGTH));
	end

	// Read indexes above the code range have no counter, so they read zero.
	assign oob     = ((read_index >> IDX_W) != 16'd0);
	assign rd_addr = is_read ? read_index[IDX_W-1:0] : next_window;

	// A read in stage one can only leave when the response register is free or draining.
	assign s1_adv    = !valid_s1 || !read_s1 || !rsp_valid_q || !rsp_stall;
	assign req_stall = tbl_busy || !s1_adv;

	// The write that completes at the same edge as a table read is not seen by that read;
	// the forwarded copy taken at that edge replaces the stale data.
	assign cur_s1  = hit_s1 ? fwd_s1 : tbl_rd_data;
	assign wr.en   = valid_s1 && inc_s1;
	assign wr.addr = ADDR_MAX_W'(addr_s1);
	assign wr.data = cur_s1 + 1'b1;

	kmerhc_table #(
		.ADDR_W (IDX_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (tbl_rd_data),
		.wr      (wr),
		.busy    (tbl_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
		end else if (accept && !is_read) begin
			window_q <= next_window;
			fill_q   <= next_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1 <= is_read;
			inc_s1  <= !is_read && push_inc;
			oob_s1  <= is_read && oob;
			addr_s1 <= rd_addr;
			hit_s1  <= wr.en && (wr.addr == ADDR_MAX_W'(rd_addr));
			fwd_s1  <= wr.data;
		end
	end

	// Response register: it frees the request side from a stalled consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1 && read_s1 && s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && read_s1 && s1_adv) begin
			count_q <= oob_s1 ? '0 : cur_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign count     = count_q;

	`KHC_ASSERT_IMP(a_read_interlock, clk, arst_n,
		valid_s1 && read_s1 && rsp_valid_q && rsp_stall, req_stall)
	`KHC_ASSERT_NXT(a_read_enters_s1, clk, arst_n, accept && is_read, valid_s1 && read_s1)
	`KHC_ASSERT_IMP(a_no_write_in_clear, clk, arst_n, tbl_busy, !wr.en && !valid_s1)
	`KHC_ASSERT_NXT(a_read_gives_rsp, clk, arst_n,
		valid_s1 && read_s1 && s1_adv, rsp_valid_q)

endmodule
